FILE: design/ppmdec_pkg.sv
// Shared types, constants and channel order tables of the PPM pulse decoder.
package ppmdec_pkg;

  localparam int LEVEL_BITS = 26;
  localparam int LAST_SLOT  = 17;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QCW        = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SLOTS_DEF    = 17;
  localparam int CHANNELS_DEF = 8;
  localparam int RUN_BITS_DEF = 16;

  localparam logic [9:0] POS_MID = 10'd512;
  localparam logic [9:0] POS_MAX = 10'd1023;

  localparam logic        MODE_RST   = 1'b0;
  localparam logic [15:0] SYNC_RST   = 16'd200;
  localparam logic [15:0] OFFSET_RST = 16'd30;
  localparam logic [15:0] GAIN_RST   = 16'd3745;
  localparam logic [9:0]  SLEW_RST   = 10'd100;
  localparam logic [15:0] DECAY_RST  = 16'd26;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECODE_MODE  = 3'd0,
    REG_SYNC_WIDTH   = 3'd1,
    REG_WIDTH_OFFSET = 3'd2,
    REG_WIDTH_GAIN   = 3'd3,
    REG_SLEW_STEP    = 3'd4,
    REG_LEVEL_DECAY  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        decode_mode;
    logic [15:0] sync_width;
    logic [15:0] width_offset;
    logic [15:0] width_gain;
    logic [9:0]  slew_step;
    logic [15:0] level_decay;
  } cfg_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           empty;
    logic           full;
  } q_stat_t;

  localparam logic [2:0] ORDER_A [8] = '{3'd2, 3'd1, 3'd3, 3'd0, 3'd4, 3'd5, 3'd6, 3'd7};
  localparam logic [2:0] ORDER_B [8] = '{3'd3, 3'd2, 3'd1, 3'd0, 3'd4, 3'd5, 3'd6, 3'd7};

  function automatic logic [2:0] chan_order(input logic mode, input logic [2:0] k);
    return mode ? ORDER_B[k] : ORDER_A[k];
  endfunction

endpackage

FILE: design/ppmdec_front.sv
// Front end: level tracking, slicing and run length counting into pulse widths.
module ppmdec_front
  import ppmdec_pkg::*;
#(
  parameter int RUN_BITS = RUN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic signed [15:0]  sample,
  input  logic [15:0]         level_decay,
  input  q_stat_t             q_stat,
  output logic                q_push,
  output logic [RUN_BITS-1:0] q_data
);

  localparam int EW = LEVEL_BITS + 1;

  logic signed [LEVEL_BITS-1:0] level_max, level_min;
  logic signed [LEVEL_BITS-1:0] level_max_next, level_min_next;
  logic                         s1_valid;
  logic signed [15:0]           s1_sample;
  logic [RUN_BITS-1:0]          high_run, low_run;
  logic [RUN_BITS-1:0]          high_run_next, low_run_next;

  logic signed [EW-1:0] mx, mn, sq, d, lvl_sum, two_sq;
  logic                 accept, is_high;

  // one slot held back for the sample now in the slicing stage
  assign sample_stall = (QCW'(q_stat.count) + QCW'(s1_valid)) >= QCW'(QDEPTH);
  assign accept = sample_valid && !sample_stall;

  always_comb begin
    d  = $signed({{(EW-16){1'b0}}, level_decay});
    sq = $signed({{(EW-24){sample[15]}}, sample, 8'h00});
    mx = EW'(level_max) - d;
    mn = EW'(level_min) + d;
    if (mx < mn) mx = mn + EW'(256);
    if (sq > mx) mx = sq;
    else if (sq < mn) mn = sq;
    level_max_next = mx[LEVEL_BITS-1:0];
    level_min_next = mn[LEVEL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_max <= '0;
      level_min <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        level_max <= level_max_next;
        level_min <= level_min_next;
      end
    end
    if (accept) s1_sample <= sample;
  end

  // slice against the levels left by the same sample
  always_comb begin
    lvl_sum = EW'(level_max) + EW'(level_min);
    two_sq  = $signed({{(EW-25){s1_sample[15]}}, s1_sample, 9'h000});
    is_high = two_sq > lvl_sum;
    high_run_next = high_run;
    low_run_next  = low_run;
    q_push = 1'b0;
    q_data = '0;
    if (s1_valid) begin
      if (is_high) begin
        if (high_run != '1) high_run_next = high_run + RUN_BITS'(1);
        if (low_run != '0) begin
          q_push       = 1'b1;
          q_data       = low_run;
          low_run_next = '0;
        end
      end else begin
        if (low_run != '1) low_run_next = low_run + RUN_BITS'(1);
        if (high_run != '0) begin
          q_push        = 1'b1;
          q_data        = high_run;
          high_run_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_run <= '0;
      low_run  <= '0;
    end else begin
      high_run <= high_run_next;
      low_run  <= low_run_next;
    end
  end

endmodule

FILE: design/ppmdec_queue.sv
// Short pulse width queue between front and back end.
module ppmdec_queue
  import ppmdec_pkg::*;
#(
  parameter int RUN_BITS = RUN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [RUN_BITS-1:0] push_data,
  input  logic                pop,
  output logic [RUN_BITS-1:0] pop_data,
  output q_stat_t             stat
);

  logic [RUN_BITS-1:0] mem [QDEPTH];
  logic [QAW-1:0]      wr_ptr, rd_ptr;
  logic [QCW-1:0]      count;

  assign pop_data   = mem[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == QCW'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop) rd_ptr <= rd_ptr + QAW'(1);
      case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

FILE: design/ppmdec_back.sv
// Back end: width mapping, frame slot tracking, smoothing and change reporting.
module ppmdec_back
  import ppmdec_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int RUN_BITS = RUN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  q_stat_t             q_stat,
  input  logic [RUN_BITS-1:0] q_data,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [2:0]          channel,
  output logic [9:0]          position
);

  localparam int WW = (RUN_BITS > 16) ? RUN_BITS : 16;
  localparam int DW = WW + 1;
  localparam int PW = DW + 17;
  localparam int TW = PW + 1;
  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(CHANNELS);
  localparam logic signed [TW-1:0] FULL_SCALE = TW'(1024 * 256);

  logic                 adv, go;
  logic                 m_valid, c_valid;
  logic signed [PW-1:0] m_q;
  logic [WW-1:0]        m_width, c_width;
  logic [9:0]           c_v;

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [TW-1:0] t;
  logic [9:0]           v;

  logic          in_frame, in_frame_next;
  logic [IW-1:0] slot_index, slot_index_next;
  logic [9:0]    slot_values [SLOTS];
  logic [9:0]    reported [CHANNELS];

  logic          fr, wr_slot, hit;
  logic [IW-1:0] idx, cnt, kk;
  logic [9:0]    s_old, s_new;
  logic [10:0]   s_sum;
  logic [2:0]    ch;
  logic [CW-1:0] ch_idx;

  // whole back pipeline moves when the output register is free or taken
  assign adv   = !result_valid || !result_stall;
  assign q_pop = adv && !q_stat.empty;
  assign go    = adv && c_valid;

  always_comb begin
    diff = $signed({1'b0, WW'(q_data)}) - $signed({1'b0, WW'(cfg.width_offset)});
    prod = diff * $signed({1'b0, cfg.width_gain});
  end

  always_comb begin
    t = cfg.decode_mode ? (FULL_SCALE - TW'(m_q)) : TW'(m_q);
    if (t[TW-1]) v = '0;
    else if (t[TW-2:18] != '0) v = POS_MAX;
    else v = t[17:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= q_pop;
      c_valid <= m_valid;
    end
    if (adv) begin
      m_q     <= prod;
      m_width <= WW'(q_data);
      c_v     <= v;
      c_width <= m_width;
    end
  end

  always_comb begin
    fr              = in_frame;
    idx             = slot_index;
    in_frame_next   = in_frame;
    slot_index_next = slot_index;
    wr_slot         = 1'b0;
    hit             = 1'b0;
    cnt             = idx + IW'(1);
    kk              = '0;
    ch              = '0;
    if (c_valid && !in_frame && (c_width > WW'(cfg.sync_width))) begin
      fr  = 1'b1;
      idx = '0;
      in_frame_next   = 1'b1;
      slot_index_next = '0;
    end
    s_old = slot_values[idx];
    s_sum = {1'b0, s_old} + {1'b0, c_v};
    if (s_old > c_v && (s_old - c_v) > cfg.slew_step) s_new = s_old - cfg.slew_step;
    else if (c_v > s_old && (c_v - s_old) > cfg.slew_step) s_new = s_old + cfg.slew_step;
    else s_new = s_sum[10:1];
    cnt = idx + IW'(1);
    if (c_valid && fr) begin
      if (idx >= IW'(LAST_SLOT)) begin
        in_frame_next = 1'b0;
      end else begin
        wr_slot         = 1'b1;
        slot_index_next = cnt;
        in_frame_next   = (cnt < IW'(LAST_SLOT));
        // odd slot counts from three on carry a reported channel
        if (cnt >= IW'(3) && cnt[0]) begin
          kk  = (cnt - IW'(3)) >> 1;
          ch  = chan_order(cfg.decode_mode, kk[2:0]);
          hit = (s_new != reported[CW'(ch)]);
        end
      end
    end
    ch_idx = CW'(ch);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      slot_index   <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_values[i] <= '0;
      for (int i = 0; i < CHANNELS; i++) reported[i] <= POS_MID;
    end else begin
      if (go) begin
        in_frame   <= in_frame_next;
        slot_index <= slot_index_next;
        if (wr_slot) slot_values[idx] <= s_new;
        if (hit) reported[ch_idx] <= s_new;
      end
      if (adv) result_valid <= go && hit;
    end
    if (go && hit) begin
      channel  <= ch;
      position <= s_new;
    end
  end

endmodule

FILE: design/ppm_audio_pulse_decoder_top.sv
// The sample that ends a run reaches result_valid through the slicing register, the
// pulse queue, the m and c registers and the output register. One sample per cycle
// unless sample_stall; the back end maps and smooths one pulse per cycle while not stalled.
// sample_stall rises only while the four entry pulse queue is backed up by result_stall.
// Reset (rst, synchronous) clears levels, runs, frame state and slots, sets reported
// positions to 512 and loads the register defaults.
module ppm_audio_pulse_decoder_top
  import ppmdec_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int RUN_BITS = RUN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic signed [15:0]    sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [2:0]            channel,
  output logic [9:0]            position,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                cfg;
  q_stat_t             q_stat;
  logic                q_push, q_pop;
  logic [RUN_BITS-1:0] q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decode_mode  <= MODE_RST;
      cfg.sync_width   <= SYNC_RST;
      cfg.width_offset <= OFFSET_RST;
      cfg.width_gain   <= GAIN_RST;
      cfg.slew_step    <= SLEW_RST;
      cfg.level_decay  <= DECAY_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DECODE_MODE:  cfg.decode_mode  <= cfg_data[0];
        REG_SYNC_WIDTH:   cfg.sync_width   <= cfg_data;
        REG_WIDTH_OFFSET: cfg.width_offset <= cfg_data;
        REG_WIDTH_GAIN:   cfg.width_gain   <= cfg_data;
        REG_SLEW_STEP:    cfg.slew_step    <= cfg_data[9:0];
        REG_LEVEL_DECAY:  cfg.level_decay  <= cfg_data;
        default:          cfg <= cfg;
      endcase
    end
  end

  ppmdec_front #(.RUN_BITS(RUN_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .level_decay  (cfg.level_decay),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  ppmdec_queue #(.RUN_BITS(RUN_BITS)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  ppmdec_back #(
    .SLOTS    (SLOTS),
    .CHANNELS (CHANNELS),
    .RUN_BITS (RUN_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_stat       (q_stat),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .channel      (channel),
    .position     (position)
  );

  // input stall must leave room for every pulse the front end can still emit
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full || q_pop)
    else $error("pulse queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pulse queue underflow");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> sample_stall)
    else $error("sample taken with full pulse queue");

endmodule

FILE: tb/ppm_audio_pulse_decoder_top_tb.sv
// Self-checking testbench for the PPM audio pulse decoder: directed sample table, then random frames.
`timescale 1ns / 100ps

module ppm_audio_pulse_decoder_top_tb;
  import ppmdec_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 8;     // margin past the pulse latency
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 50;
  localparam int NSLOT       = SLOTS_DEF;
  localparam int NCHAN       = CHANNELS_DEF;
  localparam int unsigned RUN_TOP = (1 << RUN_BITS_DEF) - 1;

  localparam logic [15:0] LVL_HI = 16'd16000;
  localparam logic [15:0] LVL_LO = 16'hC180;   // -16000
  localparam logic [15:0] FS_HI  = 16'h7FFF;
  localparam logic [15:0] FS_LO  = 16'h8000;

  localparam logic [2:0] ORDER_PLAIN   [8] = '{3'd2, 3'd1, 3'd3, 3'd0, 3'd4, 3'd5, 3'd6, 3'd7};
  localparam logic [2:0] ORDER_SWAPPED [8] = '{3'd3, 3'd2, 3'd1, 3'd0, 3'd4, 3'd5, 3'd6, 3'd7};

  typedef struct packed {
    logic [2:0] channel;
    logic [9:0] position;
  } move_t;

  // one row of the directed table: a register write or a run of equal samples
  typedef struct packed {
    logic        wr;
    cfg_reg_t    idx;
    logic [15:0] data;
    logic [15:0] smp;
    logic [16:0] reps;
    logic        typed;   // result of the first beat of the run is given below
    logic        hit;
    logic [2:0]  ch;
    logic [9:0]  pos;
  } step_t;

  logic                  clk;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  logic signed [15:0]    sample;
  logic                  result_valid;
  logic                  result_stall;
  logic [2:0]            channel;
  logic [9:0]            position;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  cfg_t        cfg;
  int          lvl_top;
  int          lvl_floor;
  int unsigned run_high;
  int unsigned run_low;
  bit          framing;
  int          slot_ptr;
  logic [9:0]  slot_pos [NSLOT];
  logic [9:0]  last_pos [NCHAN];

  move_t channel_moves [$];
  move_t want;
  step_t plan [$];

  bit calm;
  bit hold_req;
  int hold_left;
  int beats;
  int checked;
  int errors;
  int writes;
  int cycles;

  ppm_audio_pulse_decoder_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .channel      (channel),
    .position     (position),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycles++;

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout after %0d cycles, %0d updates outstanding", $time, CYCLE_LIMIT,
             channel_moves.size());
    $display("Test completed with failures");
    $finish;
  end

  // map one finished run into the current frame; returns 1 when a channel moves
  function automatic bit place_pulse(input int unsigned width,
                                     output logic [2:0] ch, output logic [9:0] pos);
    longint q;
    int     v;
    int     s;
    int     count;
    int     k;
    ch  = '0;
    pos = '0;
    if (!framing && width > cfg.sync_width) begin
      framing  = 1'b1;
      slot_ptr = 0;
    end
    if (!framing) return 1'b0;
    if (slot_ptr >= NSLOT) begin
      framing = 1'b0;
      return 1'b0;
    end
    q = (longint'(width) - longint'(cfg.width_offset)) * longint'(cfg.width_gain);
    if (cfg.decode_mode) q = 64'sd262144 - q;
    v = (q < 0) ? 0 : (q >= 64'sd262144) ? 1023 : int'(q / 256);
    s = int'(slot_pos[slot_ptr]);
    if (s - v > int'(cfg.slew_step)) s -= int'(cfg.slew_step);
    else if (v - s > int'(cfg.slew_step)) s += int'(cfg.slew_step);
    else s = (s + v) >>> 1;
    slot_pos[slot_ptr] = s[9:0];
    slot_ptr++;
    count = slot_ptr;
    if (count >= NSLOT) framing = 1'b0;
    if (count < 3 || count % 2 == 0) return 1'b0;
    k   = (count - 3) / 2;
    ch  = cfg.decode_mode ? ORDER_SWAPPED[k] : ORDER_PLAIN[k];
    pos = slot_pos[count - 1];
    if (pos == last_pos[ch]) return 1'b0;
    last_pos[ch] = pos;
    return 1'b1;
  endfunction

  // level tracking, slicing and run counting for one sample
  function automatic bit slice_sample(input logic signed [15:0] smp,
                                      output logic [2:0] ch, output logic [9:0] pos);
    int          scaled;
    int unsigned width;
    ch     = '0;
    pos    = '0;
    scaled = int'(smp) * 256;
    lvl_top   -= int'(cfg.level_decay);
    lvl_floor += int'(cfg.level_decay);
    if (lvl_top < lvl_floor) lvl_top = lvl_floor + 256;
    if (scaled > lvl_top) lvl_top = scaled;
    else if (scaled < lvl_floor) lvl_floor = scaled;
    if (2 * longint'(scaled) > longint'(lvl_floor) + longint'(lvl_top)) begin
      if (run_high < RUN_TOP) run_high++;
      if (run_low != 0) begin
        width   = run_low;
        run_low = 0;
        return place_pulse(width, ch, pos);
      end
    end else begin
      if (run_low < RUN_TOP) run_low++;
      if (run_high != 0) begin
        width    = run_high;
        run_high = 0;
        return place_pulse(width, ch, pos);
      end
    end
    return 1'b0;
  endfunction

  task automatic put_sample(input logic signed [15:0] smp, input bit typed, input bit t_hit,
                            input logic [2:0] t_ch, input logic [9:0] t_pos);
    bit         hit;
    logic [2:0] ch;
    logic [9:0] pos;
    while (!calm && $urandom_range(0, 99) < 11) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= smp;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    hit = slice_sample(smp, ch, pos);
    if (typed) begin
      hit = t_hit;
      ch  = t_ch;
      pos = t_pos;
    end
    if (hit) channel_moves.push_back('{ch, pos});
    beats++;
    @(negedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic set_reg(input cfg_reg_t idx, input logic [15:0] val);
    sample_valid <= 1'b0;
    while (channel_moves.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_DECODE_MODE:  cfg.decode_mode  = val[0];
      REG_SYNC_WIDTH:   cfg.sync_width   = val;
      REG_WIDTH_OFFSET: cfg.width_offset = val;
      REG_WIDTH_GAIN:   cfg.width_gain   = val;
      REG_SLEW_STEP:    cfg.slew_step    = val[9:0];
      REG_LEVEL_DECAY:  cfg.level_decay  = val;
      default: ;
    endcase
    writes++;
  endtask

  // result side: random stall, plus one long hold-off on request
  initial begin
    hold_left    = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(0, 99) < 11);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (channel_moves.size() == 0) begin
        $display("%0t: unexpected beat: channel %0d position %0d", $time, channel, position);
        errors++;
      end else begin
        want = channel_moves.pop_front();
        if (channel !== want.channel) begin
          $display("%0t: channel mismatch: expected %0d, got %0d", $time, want.channel,
                   channel);
          errors++;
        end
        if (position !== want.position) begin
          $display("%0t: position mismatch: expected %0d, got %0d", $time, want.position,
                   position);
          errors++;
        end
        checked++;
      end
    end
  end

  initial begin
    int          len;
    int          nrun;
    int          amp_hi;
    int          amp_lo;
    int          v;
    bit          level;
    logic [15:0] word;

    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_write    = 1'b0;
    cfg_index    = REG_DECODE_MODE;
    cfg_data     = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    beats        = 0;
    checked      = 0;
    errors       = 0;
    writes       = 0;
    level        = 1'b0;

    cfg       = '{MODE_RST, SYNC_RST, OFFSET_RST, GAIN_RST, SLEW_RST, DECAY_RST};
    lvl_top   = 0;
    lvl_floor = 0;
    run_high  = 0;
    run_low   = 0;
    framing   = 1'b0;
    slot_ptr  = 0;
    foreach (slot_pos[i]) slot_pos[i] = '0;
    foreach (last_pos[i]) last_pos[i] = POS_MID;

    // short frame: sync above 4, position = (width-2)*100, plain averaging
    plan.push_back(step_t'{1'b1, REG_SYNC_WIDTH,   16'd4,     16'd0, 17'd0, 1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b1, REG_WIDTH_OFFSET, 16'd2,     16'd0, 17'd0, 1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b1, REG_WIDTH_GAIN,   16'd25600, 16'd0, 17'd0, 1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b1, REG_SLEW_STEP,    16'd1023,  16'd0, 17'd0, 1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_LO, 17'd3,  1'b0, 1'b0, 3'd0, 10'd0});
    // runs too short to be sync and no frame open: ignored
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_HI, 17'd2,  1'b1, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_LO, 17'd6,  1'b1, 1'b0, 3'd0, 10'd0});
    // the 6-sample run opens the frame and lands in slot 0
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_HI, 17'd3,  1'b1, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_LO, 17'd2,  1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_HI, 17'd4,  1'b1, 1'b1, 3'd2, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_LO, 17'd12, 1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_HI, 17'd1,  1'b1, 1'b1, 3'd1, 10'd500});
    // width 1 maps below zero, width 13 clamps at the top
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_LO, 17'd13, 1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_HI, 17'd5,  1'b1, 1'b1, 3'd3, 10'd511});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_LO, 17'd3,  1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_HI, 17'd9,  1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_LO, 17'd2,  1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_HI, 17'd7,  1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_LO, 17'd4,  1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_HI, 17'd11, 1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_LO, 17'd3,  1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_HI, 17'd6,  1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_LO, 17'd8,  1'b0, 1'b0, 3'd0, 10'd0});
    // slot 16 closes the frame; the short runs after it are dropped
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_HI, 17'd2,  1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_LO, 17'd2,  1'b1, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, LVL_HI, 17'd1,  1'b1, 1'b0, 3'd0, 10'd0});
    // frozen levels and a long full-scale run that opens a frame
    plan.push_back(step_t'{1'b1, REG_LEVEL_DECAY, 16'd0,     16'd0, 17'd0, 1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b1, REG_SYNC_WIDTH,  16'd64,    16'd0, 17'd0, 1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, FS_HI, 17'd80, 1'b0, 1'b0, 3'd0, 10'd0});
    plan.push_back(step_t'{1'b0, REG_DECODE_MODE, 16'd0, FS_LO, 17'd3,  1'b1, 1'b0, 3'd0, 10'd0});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].wr) begin
        set_reg(plan[i].idx, plan[i].data);
      end else begin
        for (int r = 0; r < plan[i].reps; r++)
          put_sample(plan[i].smp, plan[i].typed && r == 0, plan[i].hit, plan[i].ch,
                     plan[i].pos);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      set_reg(REG_DECODE_MODE, {15'd0, p[0]});
      set_reg(REG_SYNC_WIDTH, (p == 3) ? 16'd0 : (p == 7) ? 16'd65535 :
                              16'($urandom_range(3, 12)));
      set_reg(REG_WIDTH_OFFSET, (p == 5) ? 16'd65535 : (p == 9) ? 16'd0 :
                                16'($urandom_range(0, 3)));
      set_reg(REG_WIDTH_GAIN, (p == 4) ? 16'd0 : (p == 6) ? 16'd65535 :
                              16'(262144 / $urandom_range(5, 10)));
      set_reg(REG_SLEW_STEP, (p == 2) ? 16'd0 : (p == 8) ? 16'd1023 :
                             16'($urandom_range(20, 300)));
      set_reg(REG_LEVEL_DECAY, (p == 10) ? 16'd0 : (p == 11) ? 16'd65535 :
                               16'($urandom_range(0, 200)));
      calm = (p == 6);
      if (p == 1) hold_req = 1'b1;
      len = 0;
      while (len < PHASE_BEATS) begin
        if ($urandom_range(0, 99) < 85) begin
          // sync run then a frame of pulses; short or long frames now and then
          amp_hi = $urandom_range(4000, 32767);
          amp_lo = $urandom_range(4000, 32768);
          nrun   = 1 + ((($urandom_range(0, 3)) == 0) ? $urandom_range(10, 20) : 17);
          for (int r = 0; r < nrun; r++) begin
            level = !level;
            v = (r == 0 && cfg.sync_width < 16) ? cfg.sync_width + 1 + $urandom_range(0, 2)
                                                : $urandom_range(1, 10);
            repeat (v) begin
              word = level ? 16'(amp_hi - $urandom_range(0, 999))
                           : 16'($urandom_range(0, 999) - amp_lo);
              put_sample(word, 1'b0, 1'b0, 3'd0, 10'd0);
              len++;
            end
          end
        end else begin
          repeat ($urandom_range(3, 12)) begin
            word = 16'($urandom_range(0, 65535));
            put_sample(word, 1'b0, 1'b0, 3'd0, 10'd0);
            len++;
          end
        end
      end
    end
    calm = 1'b0;

    sample_valid <= 1'b0;
    while (channel_moves.size() != 0) @(negedge clk);
    repeat (2 * DRAIN) @(negedge clk);

    $display("Sent %0d samples over %0d cycles with %0d register writes in %0d setups;",
             beats, cycles, writes, PHASES + 2);
    $display("checked %0d channel updates, including a long full-scale run and an output hold.",
             checked);
    if (errors == 0 && channel_moves.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ppmdec_pkg.sv
design/ppmdec_front.sv
design/ppmdec_queue.sv
design/ppmdec_back.sv
design/ppm_audio_pulse_decoder_top.sv
tb/ppm_audio_pulse_decoder_top_tb.sv
